// File: rtl/uasmd_pkg.sv
// Package: widths, command and status codes, and sequencer states for the unsigned ALU.
package uasmd_pkg;

  // Operand width actually used by the datapath (1..32); port fields stay fixed.
  localparam int unsigned WIDTH = 32;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned OP_W  = 32;
  localparam int unsigned RES_W = 64;
  localparam int unsigned REM_W = 32;
  localparam int unsigned ST_W  = 2;

  // Step counter indexes 0 .. WIDTH-1
  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_DIVZERO   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_DONE = 2'd2
  } state_e;

endpackage

// File: rtl/uasmd_if.sv
// Interfaces: command channel and result channel of the unsigned ALU.
interface uasmd_in_if;
  logic                         valid;
  logic                         ready;
  logic [uasmd_pkg::CMD_W-1:0]  cmd;
  logic [uasmd_pkg::OP_W-1:0]   operand_a;
  logic [uasmd_pkg::OP_W-1:0]   operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface uasmd_out_if;
  logic                         valid;
  logic                         ready;
  logic [uasmd_pkg::RES_W-1:0]  main_result;
  logic [uasmd_pkg::REM_W-1:0]  remainder_out;
  logic [uasmd_pkg::ST_W-1:0]   status;

  modport source (output valid, output main_result, output remainder_out, output status,
                  input ready);
  modport sink   (input valid, input main_result, input remainder_out, input status,
                  output ready);
endinterface

// File: rtl/uasmd_alu.sv
// Shared WIDTH+1 bit adder/subtractor with carry out.
module uasmd_alu (
  input  logic [uasmd_pkg::WIDTH:0] x_i,
  input  logic [uasmd_pkg::WIDTH:0] y_i,
  input  logic                      sub_i,
  output logic [uasmd_pkg::WIDTH:0] sum_o,
  output logic                      carry_o
);

  // sub: x + ~y + 1; carry set means x >= y
  assign {carry_o, sum_o} = {1'b0, x_i}
                          + {1'b0, y_i ^ {(uasmd_pkg::WIDTH + 1){sub_i}}}
                          + (uasmd_pkg::WIDTH + 2)'(sub_i);

endmodule

// File: rtl/unsigned_add_sub_mul_div.sv
// Top level: unsigned add / subtract / shift-add multiply / restoring divide.
//
// Usage
//   in_i  : command transfer (cmd, operand_a, operand_b), valid/ready.
//   out_o : result transfer (main_result, remainder_out, status), valid/ready.
//   Only the low WIDTH bits of each operand are used.
//   One result per command. Commands are handled one at a time.
// Sequence (accept to result valid)
//   add, sub          : the add or subtract in RUN, then DONE loads the result
//   mul, div          : one adder step per operand bit in RUN, then DONE
//   div by zero       : no division steps, status DIVZERO, result fields zero
//   One shared WIDTH+1 bit adder does every step; mul and div use it once per
//   operand bit. A new command is taken only in IDLE, or in DONE as the result
//   is handed to the output register, so commands never overlap.
// Stall
//   Results sit in an output register. If it is still full when the next
//   result is finished, the sequencer holds in DONE and in_i.ready stays low
//   until the sink takes the pending transfer.
// Reset
//   rst_ni low (async) returns to IDLE with no result pending.
module unsigned_add_sub_mul_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  uasmd_in_if.sink    in_i,
  uasmd_out_if.source out_o
);

  localparam int unsigned W = uasmd_pkg::WIDTH;

  // sequencer
  uasmd_pkg::state_e  state_q, state_d;
  logic [uasmd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic               in_acc;
  logic               out_free;
  logic               load_out;
  logic               last_step;
  logic               op_done;
  logic               b_zero;

  // operand and working registers
  uasmd_pkg::cmd_e    cmd_q, cmd_d;
  logic [W-1:0]       a_q, a_d;
  logic [W-1:0]       b_q, b_d;
  logic [W-1:0]       hi_q, hi_d;   // mul: upper product / div: partial remainder
  logic [W-1:0]       lo_q, lo_d;   // mul: multiplier+lower product / div: dividend->quotient
  uasmd_pkg::status_e stat_q, stat_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [uasmd_pkg::RES_W-1:0]  res_q, res_d;
  logic [uasmd_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [uasmd_pkg::ST_W-1:0]   ost_q, ost_d;

  // shared adder
  logic [W:0]         alu_x, alu_y, alu_sum;
  logic               alu_sub, alu_carry;

  uasmd_alu u_alu (
    .x_i     (alu_x),
    .y_i     (alu_y),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_acc    = in_i.valid && in_i.ready;
  assign b_zero    = (b_q == '0);
  assign last_step = (cnt_q == uasmd_pkg::CNT_W'(W - 1));
  assign op_done   = (cmd_q == uasmd_pkg::CMD_ADD) || (cmd_q == uasmd_pkg::CMD_SUB)
                  || ((cmd_q == uasmd_pkg::CMD_DIV) && b_zero) || last_step;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      uasmd_pkg::S_IDLE: begin
        if (in_acc) state_d = uasmd_pkg::S_RUN;
      end
      uasmd_pkg::S_RUN: begin
        if (op_done) state_d = uasmd_pkg::S_DONE;
      end
      uasmd_pkg::S_DONE: begin
        if (out_free) state_d = in_acc ? uasmd_pkg::S_RUN : uasmd_pkg::S_IDLE;
      end
      default: state_d = uasmd_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: take a command when idle or while handing off a result
  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      uasmd_pkg::S_IDLE: in_i.ready = 1'b1;
      uasmd_pkg::S_RUN:  in_i.ready = 1'b0;
      uasmd_pkg::S_DONE: begin
        in_i.ready = out_free;
        load_out   = out_free;
      end
      default: in_i.ready = 1'b0;
    endcase
  end

  // adder operand select
  always_comb begin
    alu_x   = {1'b0, a_q};
    alu_y   = {1'b0, b_q};
    alu_sub = 1'b0;
    unique case (cmd_q)
      uasmd_pkg::CMD_ADD: alu_sub = 1'b0;
      uasmd_pkg::CMD_SUB: alu_sub = 1'b1;
      uasmd_pkg::CMD_MUL: begin
        alu_x = {1'b0, hi_q};
        alu_y = lo_q[0] ? {1'b0, a_q} : '0;
      end
      uasmd_pkg::CMD_DIV: begin
        // trial subtract of divisor from remainder with next dividend bit
        alu_x   = {hi_q, lo_q[W-1]};
        alu_sub = 1'b1;
      end
      default: alu_sub = 1'b0;
    endcase
  end

  // working registers
  always_comb begin
    cmd_d  = cmd_q;
    a_d    = a_q;
    b_d    = b_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    stat_d = stat_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      cmd_d  = uasmd_pkg::cmd_e'(in_i.cmd);
      a_d    = in_i.operand_a[W-1:0];
      b_d    = in_i.operand_b[W-1:0];
      hi_d   = '0;
      lo_d   = (uasmd_pkg::cmd_e'(in_i.cmd) == uasmd_pkg::CMD_DIV) ? in_i.operand_a[W-1:0]
                                                                    : in_i.operand_b[W-1:0];
      stat_d = uasmd_pkg::ST_OK;
      cnt_d  = '0;
    end else if (state_q == uasmd_pkg::S_RUN) begin
      cnt_d = op_done ? '0 : cnt_q + 1'b1;
      unique case (cmd_q)
        uasmd_pkg::CMD_ADD: begin
          lo_d = alu_sum[W-1:0];
          hi_d = W'(alu_sum[W]);
        end
        uasmd_pkg::CMD_SUB: begin
          lo_d   = alu_sum[W-1:0];
          hi_d   = '0;
          stat_d = alu_carry ? uasmd_pkg::ST_OK : uasmd_pkg::ST_UNDERFLOW;
        end
        uasmd_pkg::CMD_MUL: begin
          // shift the partial sum right into the product
          hi_d = alu_sum[W:1];
          lo_d = W'({alu_sum[0], lo_q} >> 1);
        end
        uasmd_pkg::CMD_DIV: begin
          if (b_zero) begin
            hi_d   = '0;
            lo_d   = '0;
            stat_d = uasmd_pkg::ST_DIVZERO;
          end else if (alu_carry) begin
            hi_d = alu_sum[W-1:0];
            lo_d = W'({lo_q, 1'b1});
          end else begin
            hi_d = W'({hi_q, lo_q[W-1]});
            lo_d = W'({lo_q, 1'b0});
          end
        end
        default: cnt_d = '0;
      endcase
    end
  end

  // output register
  always_comb begin
    res_d       = res_q;
    rem_d       = rem_q;
    ost_d       = ost_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      ost_d       = stat_q;
      if (cmd_q == uasmd_pkg::CMD_DIV) begin
        res_d = uasmd_pkg::RES_W'(lo_q);
        rem_d = uasmd_pkg::REM_W'(hi_q);
      end else begin
        res_d = uasmd_pkg::RES_W'({hi_q, lo_q});
        rem_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uasmd_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    b_q    <= b_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    stat_q <= stat_d;
    res_q  <= res_d;
    rem_q  <= rem_d;
    ost_q  <= ost_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.main_result   = res_q;
  assign out_o.remainder_out = rem_q;
  assign out_o.status        = ost_q;

  // checks
  a_acc_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == uasmd_pkg::S_RUN)
    else $error("accepted command did not start the sequencer");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != uasmd_pkg::S_RUN |-> cnt_q == '0)
    else $error("step counter not cleared outside RUN");

  a_divzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ost_q == uasmd_pkg::ST_DIVZERO |-> res_q == '0 && rem_q == '0)
    else $error("divide by zero returned nonzero result");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ost_q == uasmd_pkg::ST_UNDERFLOW |-> rem_q == '0)
    else $error("underflow result carries a remainder");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !load_out)
    else $error("pending result overwritten");

endmodule
